// ===== rtl/core/ubxpp_pkg.sv =====
// shared types and constants for the position message body parser
`timescale 1ns / 1ps

package ubxpp_pkg;

  localparam int PayloadBytesDef  = 28;
  localparam int FieldFirstOffset = 4;
  localparam int FieldCount       = 4;
  localparam int FieldW           = 32;
  localparam int FieldIdxW        = $clog2(FieldCount);
  localparam int CfgIdxW          = 1;

  localparam logic [7:0] ClassReset = 8'd1;
  localparam logic [7:0] IdReset    = 8'd2;

  localparam logic [CfgIdxW-1:0] CFG_MESSAGE_CLASS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MESSAGE_ID    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LEN   = 2'd1,
    ST_SUM   = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [FieldW-1:0] longitude;
    logic signed [FieldW-1:0] latitude;
    logic signed [FieldW-1:0] ellipsoid_height;
    logic signed [FieldW-1:0] sea_level_height;
  } out_item_t;

  // checksum unit control
  typedef struct packed {
    logic       seed;
    logic       fold;
    logic [7:0] data;
  } cks_ctrl_t;

endpackage

// ===== rtl/core/ubx_posllh_frame_parser.sv =====
// top level of the position message body parser
`timescale 1ns / 1ps

// Usage:
//   in channel (in_valid_i/in_ready_o/in_item_i) carries one body byte per
//   transfer, starting with the two length bytes, or an end-of-stream marker
//   (kind set). out channel (out_valid_o/out_ready_i/out_item_o) carries one
//   result per message: ok, length mismatch, checksum mismatch or truncated.
//   cfg channel writes message_class (index 0) or message_id (index 1); it is
//   always ready and the seed is sampled when the length low byte arrives.
// Timing:
//   one transfer per cycle unless a held result stalls the input; a result
//   appears on out_valid_o in the cycle after the input transfer that
//   completes it. All per-byte work (checksum fold, field capture,
//   length/check compare) sits between the position and result registers.
// Stall:
//   a held result keeps the output register; the input side still takes
//   bytes while out_ready_i is high or the output register is empty.
// Reset:
//   clears position and checksum, registers return to class 1 / id 2, no
//   result pending. No clearing pass is needed.

module ubx_posllh_frame_parser
  import ubxpp_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PayloadBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int PosW = $clog2(PAYLOAD_BYTES + 4);
  localparam logic [PosW-1:0] PayEnd   = PosW'(PAYLOAD_BYTES + 2);
  localparam logic [PosW-1:0] FieldLo  = PosW'(FieldFirstOffset + 2);
  localparam logic [PosW-1:0] FieldHi  = PosW'(FieldFirstOffset + 2 + 4 * FieldCount);
  localparam logic [15:0]     LenExp   = 16'(PAYLOAD_BYTES);
  localparam logic [PosW-1:0] PosLenLo = PosW'(0);
  localparam logic [PosW-1:0] PosLenHi = PosW'(1);
  localparam logic [PosW-1:0] PosOne   = PosW'(1);

  logic [7:0]      class_q, id_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      len_low_q, len_low_d;
  logic [7:0]      first_chk_q, first_chk_d;
  logic [FieldW-1:0] field_q [FieldCount];
  logic            out_valid_q;
  out_item_t       out_q;

  logic            take;
  logic            emit;
  status_e         status;
  logic            with_fields;
  logic            cap_en;
  logic [PosW-1:0] rel;
  logic [FieldIdxW-1:0] cap_idx;
  logic [1:0]      cap_lane;
  cks_ctrl_t       cks_ctrl;
  logic [7:0]      sum_a, sum_b;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q <= ClassReset;
      id_q    <= IdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MESSAGE_CLASS: class_q <= cfg_data_i;
        CFG_MESSAGE_ID:    id_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ubxpp_cksum u_cksum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cks_ctrl),
    .msg_class_i(class_q),
    .msg_id_i   (id_q),
    .sum_a_o    (sum_a),
    .sum_b_o    (sum_b)
  );

  assign rel      = pos_q - FieldLo;
  assign cap_idx  = rel[FieldIdxW+1:2];
  assign cap_lane = rel[1:0];

  always_comb begin
    pos_d         = pos_q;
    len_low_d     = len_low_q;
    first_chk_d   = first_chk_q;
    emit          = 1'b0;
    status        = ST_OK;
    with_fields   = 1'b0;
    cap_en        = 1'b0;
    cks_ctrl.seed = 1'b0;
    cks_ctrl.fold = 1'b0;
    cks_ctrl.data = in_item_i.data_byte;
    if (take) begin
      if (in_item_i.kind) begin
        emit        = 1'b1;
        status      = ST_TRUNC;
        with_fields = (pos_q >= PayEnd);
        pos_d       = PosLenLo;
      end else if (pos_q == PosLenLo) begin
        cks_ctrl.seed = 1'b1;
        len_low_d     = in_item_i.data_byte;
        pos_d         = PosLenHi;
      end else if (pos_q == PosLenHi) begin
        cks_ctrl.fold = 1'b1;
        if ({in_item_i.data_byte, len_low_q} != LenExp) begin
          emit   = 1'b1;
          status = ST_LEN;
          pos_d  = PosLenLo;
        end else begin
          pos_d = pos_q + PosOne;
        end
      end else if (pos_q < PayEnd) begin
        cks_ctrl.fold = 1'b1;
        cap_en        = (pos_q >= FieldLo) && (pos_q < FieldHi);
        pos_d         = pos_q + PosOne;
      end else if (pos_q == PayEnd) begin
        first_chk_d = in_item_i.data_byte;
        pos_d       = pos_q + PosOne;
      end else begin
        emit        = 1'b1;
        with_fields = 1'b1;
        status      = ((first_chk_q == sum_a) && (in_item_i.data_byte == sum_b))
                      ? ST_OK : ST_SUM;
        pos_d       = PosLenLo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosLenLo;
      len_low_q   <= 8'd0;
      first_chk_q <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      len_low_q   <= len_low_d;
      first_chk_q <= first_chk_d;
      if (take && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // every field byte is rewritten before fields can be reported
  always_ff @(posedge clk_i) begin
    if (cap_en) begin
      field_q[cap_idx][cap_lane*8 +: 8] <= in_item_i.data_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q.status           <= status;
      out_q.longitude        <= with_fields ? field_q[0] : '0;
      out_q.latitude         <= with_fields ? field_q[1] : '0;
      out_q.ellipsoid_height <= with_fields ? field_q[2] : '0;
      out_q.sea_level_height <= with_fields ? field_q[3] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && emit) |=> (pos_q == PosLenLo))
    else $error("parser not idle after a result");

  a_result_needs_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(take))
    else $error("result appeared without an input transfer");

  a_first_check_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !in_item_i.kind && pos_q == PayEnd)
      |=> (first_chk_q == $past(in_item_i.data_byte)) && (pos_q == PayEnd + PosOne))
    else $error("first check byte not captured");
`endif

endmodule

// ===== rtl/core/ubxpp_cksum.sv =====
// 8-bit fletcher checksum accumulator, seeded with class and id
`timescale 1ns / 1ps

module ubxpp_cksum
  import ubxpp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cks_ctrl_t ctrl_i,
  input  logic [7:0] msg_class_i,
  input  logic [7:0] msg_id_i,
  output logic [7:0] sum_a_o,
  output logic [7:0] sum_b_o
);

  logic [7:0] sum_a_q, sum_a_d;
  logic [7:0] sum_b_q, sum_b_d;

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (ctrl_i.seed) begin
      // fold class, id and the first byte from a zero start
      sum_a_d = msg_class_i + msg_id_i + ctrl_i.data;
      sum_b_d = msg_class_i + {msg_class_i[6:0], 1'b0} + {msg_id_i[6:0], 1'b0}
                + ctrl_i.data;
    end else if (ctrl_i.fold) begin
      sum_a_d = sum_a_q + ctrl_i.data;
      sum_b_d = sum_b_q + sum_a_q + ctrl_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= 8'd0;
      sum_b_q <= 8'd0;
    end else begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  assign sum_a_o = sum_a_q;
  assign sum_b_o = sum_b_q;

endmodule

// ===== tb/tb_ubx_posllh_frame_parser.sv =====
// self-checking testbench for the position message body parser
`timescale 1ns / 1ps

module tb_ubx_posllh_frame_parser;
  import ubxpp_pkg::*;

  localparam int PayloadLen = PayloadBytesDef;
  localparam int FrameLen   = PayloadLen + 4;
  localparam int PhaseItems = 235;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_LEN,
    FR_CUT
  } frame_shape_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item     = '0;
  logic               out_valid_o;
  logic               out_ready   = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [7:0]         cfg_data    = '0;

  // stimulus and expected fixes
  in_item_t  body_bytes[$];
  out_item_t pending_fixes[$];
  int        error_count = 0;
  int        phase_items = 0;

  // parser mirror
  logic [7:0]  cfg_class;
  logic [7:0]  cfg_id;
  logic [10:0] rx_pos;
  logic [7:0]  len_lo_q;
  logic [7:0]  cks_a;
  logic [7:0]  cks_b;
  logic [31:0] fld [FieldCount];
  logic [7:0]  chk0_q;

  ubx_posllh_frame_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  function automatic void clear_frame();
    rx_pos   = '0;
    len_lo_q = '0;
    cks_a    = '0;
    cks_b    = '0;
    chk0_q   = '0;
    for (int k = 0; k < FieldCount; k++) fld[k] = '0;
  endfunction

  function automatic void cks_fold(logic [7:0] b);
    cks_a = cks_a + b;
    cks_b = cks_b + cks_a;
  endfunction

  // advance the mirror by one body byte, queue the fix it completes
  function automatic void parse_body_byte(in_item_t it);
    int          off;
    logic        done;
    logic        with_fields;
    status_e     st;
    out_item_t   fix;
    done        = 1'b0;
    with_fields = 1'b0;
    st          = ST_OK;
    if (it.kind) begin
      done        = 1'b1;
      st          = ST_TRUNC;
      with_fields = (rx_pos >= PayloadLen + 2);
    end else if (rx_pos == 0) begin
      cks_a = '0;
      cks_b = '0;
      cks_fold(cfg_class);
      cks_fold(cfg_id);
      cks_fold(it.data_byte);
      len_lo_q = it.data_byte;
      rx_pos   = 11'd1;
    end else if (rx_pos == 1) begin
      cks_fold(it.data_byte);
      if ({it.data_byte, len_lo_q} != 16'(PayloadLen)) begin
        done = 1'b1;
        st   = ST_LEN;
      end else begin
        rx_pos = 11'd2;
      end
    end else if (rx_pos < PayloadLen + 2) begin
      cks_fold(it.data_byte);
      off = int'(rx_pos) - 2 - FieldFirstOffset;
      if (off >= 0 && off < 4 * FieldCount) fld[off / 4][(off % 4) * 8 +: 8] = it.data_byte;
      rx_pos = rx_pos + 11'd1;
    end else if (rx_pos == PayloadLen + 2) begin
      chk0_q = it.data_byte;
      rx_pos = rx_pos + 11'd1;
    end else begin
      done        = 1'b1;
      with_fields = 1'b1;
      st          = (chk0_q == cks_a && it.data_byte == cks_b) ? ST_OK : ST_SUM;
    end
    if (done) begin
      fix.status           = st;
      fix.longitude        = with_fields ? fld[0] : '0;
      fix.latitude         = with_fields ? fld[1] : '0;
      fix.ellipsoid_height = with_fields ? fld[2] : '0;
      fix.sea_level_height = with_fields ? fld[3] : '0;
      pending_fixes.push_back(fix);
      clear_frame();
    end
  endfunction

  function automatic void push_item(logic kind, logic [7:0] b);
    in_item_t it;
    it.kind      = kind;
    it.data_byte = b;
    body_bytes.push_back(it);
    parse_body_byte(it);
    phase_items++;
  endfunction

  function automatic logic [31:0] pick_field(logic extreme, int k);
    logic [31:0] corner [4];
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    if (extreme) return corner[k];
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // one message body; cut < 0 picks a random cut point for truncated frames
  task automatic send_frame(frame_shape_e shape, logic extreme, int cut);
    logic [7:0]  pay [PayloadLen];
    logic [15:0] len;
    logic [31:0] val;
    logic [7:0]  flip_a;
    logic [7:0]  flip_b;
    int          n;
    int          sel;
    for (n = 0; n < PayloadLen; n++) pay[n] = 8'($urandom);
    for (n = 0; n < FieldCount; n++) begin
      val = pick_field(extreme, n);
      for (int j = 0; j < 4; j++) pay[FieldFirstOffset + 4 * n + j] = val[8 * j +: 8];
    end
    len = 16'(PayloadLen);
    if (shape == FR_BAD_LEN) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) len = 16'h0000;
      else if (sel == 1) len = 16'hFFFF;
      else len = len ^ (16'h1 << $urandom_range(0, 15));
    end
    flip_a = '0;
    flip_b = '0;
    if (shape == FR_BAD_SUM) begin
      sel = $urandom_range(0, 2);
      if (sel != 1) flip_a = 8'($urandom_range(1, 255));
      if (sel != 0) flip_b = 8'($urandom_range(1, 255));
    end
    if (shape != FR_CUT) cut = FrameLen;
    else if (cut < 0) cut = $urandom_range(0, FrameLen - 1);
    for (n = 0; n < FrameLen; n++) begin
      if (n == cut) begin
        push_item(1'b1, 8'($urandom));
        return;
      end
      if (n == 0) begin
        push_item(1'b0, len[7:0]);
      end else if (n == 1) begin
        push_item(1'b0, len[15:8]);
        if (shape == FR_BAD_LEN) return;
      end else if (n < PayloadLen + 2) begin
        push_item(1'b0, pay[n - 2]);
      end else if (n == PayloadLen + 2) begin
        // mirror sums already cover length and payload
        push_item(1'b0, cks_a ^ flip_a);
      end else begin
        push_item(1'b0, cks_b ^ flip_b);
      end
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_MESSAGE_CLASS) cfg_class = val;
    else if (idx == CFG_MESSAGE_ID) cfg_id = val;
  endtask

  task automatic wait_drained();
    while (body_bytes.size() != 0 || in_valid || pending_fixes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_traffic();
    int sel;
    int n;
    phase_items = 0;
    while (phase_items < PhaseItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) send_frame(FR_GOOD, 1'b0, -1);
      else if (sel < 70) send_frame(FR_BAD_SUM, 1'b0, -1);
      else if (sel < 80) send_frame(FR_BAD_LEN, 1'b0, -1);
      else if (sel < 92) send_frame(FR_CUT, 1'b0, -1);
      else begin
        n = $urandom_range(1, 5);
        repeat (n) push_item($urandom_range(0, 7) == 0, 8'($urandom));
      end
    end
    // leave the parser between frames so the next register write is safe
    if (rx_pos != 0) push_item(1'b1, 8'($urandom));
  endtask

  // input driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (body_bytes.size() != 0) begin
        in_item  <= body_bytes.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // result monitor with its own stall pattern
  int fixes_seen = 0;
  int mon_cycle  = 0;
  int hold_left  = 0;
  int stall_mode = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t fix;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (pending_fixes.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_item_o);
          error_count++;
        end else begin
          fix = pending_fixes.pop_front();
          check_field("status", 32'(fix.status), 32'(out_item_o.status));
          check_field("longitude", fix.longitude, out_item_o.longitude);
          check_field("latitude", fix.latitude, out_item_o.latitude);
          check_field("ellipsoid_height", fix.ellipsoid_height,
                      out_item_o.ellipsoid_height);
          check_field("sea_level_height", fix.sea_level_height,
                      out_item_o.sea_level_height);
        end
        fixes_seen++;
        // long hold-off so the output stays full and the input backs up
        if (fixes_seen == 30 || fixes_seen == 120) hold_left = 150;
      end
      mon_cycle++;
      if (mon_cycle % 128 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ((mon_cycle % 5) < 2);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0] cls_set [6];
    logic [7:0] id_set  [6];
    cls_set = '{8'h00, 8'hFF, 8'h01, 8'($urandom), 8'h00, 8'($urandom)};
    id_set  = '{8'h00, 8'hFF, 8'h07, 8'($urandom), 8'hFF, 8'($urandom)};
    cfg_class = ClassReset;
    cfg_id    = IdReset;
    clear_frame();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: end of stream while idle, length corners, truncation points
    push_item(1'b1, 8'hFF);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'(PayloadLen));
    push_item(1'b0, 8'h01);
    push_item(1'b0, 8'(PayloadLen) ^ 8'h01);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'(PayloadLen));
    push_item(1'b1, 8'h00);
    send_frame(FR_GOOD, 1'b1, -1);
    send_frame(FR_CUT, 1'b1, PayloadLen + 2);
    send_frame(FR_CUT, 1'b0, PayloadLen + 3);
    send_frame(FR_BAD_SUM, 1'b1, -1);
    random_traffic();
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_MESSAGE_CLASS, cls_set[p]);
      write_reg(CFG_MESSAGE_ID, id_set[p]);
      random_traffic();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ubxpp_pkg.sv
rtl/core/ubxpp_cksum.sv
rtl/core/ubx_posllh_frame_parser.sv
tb/tb_ubx_posllh_frame_parser.sv
